FILE: rtl/core/hdkp_pkg.sv
package hdkp_pkg;

    // parser phase
    typedef enum logic [2:0] {
        PH_PREFIX     = 3'd0,
        PH_AFTER_M    = 3'd1,
        PH_COMPONENT  = 3'd2,
        PH_AFTER_MARK = 3'd3,
        PH_DRAIN      = 3'd4
    } phase_t;

    // result kinds
    typedef enum logic [1:0] {
        KIND_CHILD  = 2'd0,
        KIND_ACCEPT = 2'd1,
        KIND_REJECT = 2'd2
    } kind_t;

    // reject causes
    typedef enum logic [2:0] {
        CAUSE_NONE      = 3'd0,
        CAUSE_PREFIX    = 3'd1,
        CAUSE_NO_DIGITS = 3'd2,
        CAUSE_TOO_LARGE = 3'd3,
        CAUSE_STRAY     = 3'd4
    } cause_t;

    // character codes
    localparam logic [7:0] CH_END    = 8'h00;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_H   = 8'h48;
    localparam logic [7:0] CH_UP_M   = 8'h4d;
    localparam logic [7:0] CH_LO_H   = 8'h68;
    localparam logic [7:0] CH_LO_M   = 8'h6d;

    localparam int unsigned ACC_W = 31;

    // one result item
    typedef struct packed {
        kind_t       kind;
        logic [31:0] index;
        logic        hard;
        cause_t      cause;
        logic        last;
    } result_t;

    // results produced by one character
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } step_out_t;

endpackage

FILE: rtl/core/hdkp_parse.sv
module hdkp_parse
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic [7:0]        char_code,
    output hdkp_pkg::step_out_t step
);
    import hdkp_pkg::*;

    logic [7:0]       char_reg;
    logic             char_valid_reg;
    phase_t           phase_reg;
    phase_t           phase_next;
    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] acc_next;
    logic             digits_reg;
    logic             digits_next;

    logic             is_digit;
    logic             is_mark;
    logic             is_end;
    logic             is_slash;
    logic             is_m;
    logic [34:0]      prod;
    logic             ovf;
    phase_t           rej_phase;

    function automatic result_t mk_child(input logic [ACC_W-1:0] idx, input logic hard);
        result_t r;
        r.kind  = KIND_CHILD;
        r.index = {hard, idx};
        r.hard  = hard;
        r.cause = CAUSE_NONE;
        r.last  = 1'b0;
        return r;
    endfunction

    function automatic result_t mk_close(input kind_t kind, input cause_t cause);
        result_t r;
        r.kind  = kind;
        r.index = 32'd0;
        r.hard  = 1'b0;
        r.cause = cause;
        r.last  = 1'b1;
        return r;
    endfunction

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_valid_reg <= 1'b0;
        end
        else
        begin
            char_valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg <= char_code;
        end
    end

    // character classes
    assign is_digit  = (char_reg >= CH_ZERO) && (char_reg <= CH_NINE);
    assign is_mark   = (char_reg == CH_APOS) || (char_reg == CH_LO_H) || (char_reg == CH_UP_H);
    assign is_end    = (char_reg == CH_END);
    assign is_slash  = (char_reg == CH_SLASH);
    assign is_m      = (char_reg == CH_LO_M) || (char_reg == CH_UP_M);
    assign rej_phase = is_end ? PH_PREFIX : PH_DRAIN;

    // times ten plus digit, flag any reach of the hardened bit
    assign prod = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + {31'd0, char_reg[3:0]};
    assign ovf  = |prod[34:31];

    // next state
    always_comb
    begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        digits_next = digits_reg;
        if (char_valid_reg)
        begin
            case (phase_reg)
                PH_DRAIN:
                begin
                    if (is_end)
                    begin
                        phase_next  = PH_PREFIX;
                        acc_next    = '0;
                        digits_next = 1'b0;
                    end
                end
                PH_AFTER_M:
                begin
                    acc_next    = '0;
                    digits_next = 1'b0;
                    if (is_slash)
                        phase_next = PH_COMPONENT;
                    else if (is_end)
                        phase_next = PH_PREFIX;
                    else
                        phase_next = rej_phase;
                end
                PH_COMPONENT:
                begin
                    if (is_digit && !ovf)
                    begin
                        acc_next    = prod[ACC_W-1:0];
                        digits_next = 1'b1;
                    end
                    else
                    begin
                        acc_next    = '0;
                        digits_next = 1'b0;
                        if (is_digit)
                            phase_next = rej_phase;
                        else if (!digits_reg)
                            phase_next = is_end ? PH_PREFIX : rej_phase;
                        else if (is_mark)
                            phase_next = PH_AFTER_MARK;
                        else if (is_slash)
                            phase_next = PH_COMPONENT;
                        else if (is_end)
                            phase_next = PH_PREFIX;
                        else
                            phase_next = rej_phase;
                    end
                end
                PH_AFTER_MARK:
                begin
                    acc_next    = '0;
                    digits_next = 1'b0;
                    if (is_slash)
                        phase_next = PH_COMPONENT;
                    else if (is_end)
                        phase_next = PH_PREFIX;
                    else
                        phase_next = rej_phase;
                end
                default:
                begin
                    acc_next    = '0;
                    digits_next = 1'b0;
                    if (is_m)
                        phase_next = PH_AFTER_M;
                    else if (is_slash)
                        phase_next = PH_COMPONENT;
                    else if (is_end)
                        phase_next = PH_PREFIX;
                    else
                        phase_next = rej_phase;
                end
            endcase
        end
    end

    // results of the current character
    always_comb
    begin
        step.count  = 2'd0;
        step.first  = '0;
        step.second = '0;
        if (char_valid_reg)
        begin
            case (phase_reg)
                PH_DRAIN:
                begin
                    step.count = 2'd0;
                end
                PH_AFTER_M:
                begin
                    if (!is_slash)
                    begin
                        step.count = 2'd1;
                        step.first = is_end ? mk_close(KIND_ACCEPT, CAUSE_NONE)
                                            : mk_close(KIND_REJECT, CAUSE_PREFIX);
                    end
                end
                PH_COMPONENT:
                begin
                    if (is_digit)
                    begin
                        if (ovf)
                        begin
                            step.count = 2'd1;
                            step.first = mk_close(KIND_REJECT, CAUSE_TOO_LARGE);
                        end
                    end
                    else if (!digits_reg)
                    begin
                        step.count = 2'd1;
                        step.first = is_end ? mk_close(KIND_ACCEPT, CAUSE_NONE)
                                            : mk_close(KIND_REJECT, CAUSE_NO_DIGITS);
                    end
                    else if (is_mark)
                    begin
                        step.count = 2'd1;
                        step.first = mk_child(acc_reg, 1'b1);
                    end
                    else
                    begin
                        step.first = mk_child(acc_reg, 1'b0);
                        if (is_slash)
                        begin
                            step.count = 2'd1;
                        end
                        else
                        begin
                            step.count  = 2'd2;
                            step.second = is_end ? mk_close(KIND_ACCEPT, CAUSE_NONE)
                                                 : mk_close(KIND_REJECT, CAUSE_STRAY);
                        end
                    end
                end
                PH_AFTER_MARK:
                begin
                    if (!is_slash)
                    begin
                        step.count = 2'd1;
                        step.first = is_end ? mk_close(KIND_ACCEPT, CAUSE_NONE)
                                            : mk_close(KIND_REJECT, CAUSE_STRAY);
                    end
                end
                default:
                begin
                    if (!is_m && !is_slash)
                    begin
                        step.count = 2'd1;
                        step.first = is_end ? mk_close(KIND_ACCEPT, CAUSE_NONE)
                                            : mk_close(KIND_REJECT, CAUSE_PREFIX);
                    end
                end
            endcase
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_PREFIX;
            acc_reg    <= '0;
            digits_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            acc_reg    <= acc_next;
            digits_reg <= digits_next;
        end
    end

    // a second result always closes the path after a child
    a_two_results_child_first: assert property (@(posedge clk) disable iff (!rst_n)
        (step.count == 2'd2) |-> (step.first.kind == KIND_CHILD) && step.second.last)
        else $error("second result without a leading child");

    // digits only accumulate inside a component
    a_digits_in_component: assert property (@(posedge clk) disable iff (!rst_n)
        digits_reg |-> (phase_reg == PH_COMPONENT))
        else $error("digit flag set outside a component");

    // draining holds a cleared component
    a_drain_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DRAIN) |-> (acc_reg == '0) && !digits_reg)
        else $error("accumulator not cleared while draining");

endmodule

FILE: rtl/core/hdkp_rfifo.sv
module hdkp_rfifo #(
    parameter int unsigned DEPTH = 8
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  hdkp_pkg::step_out_t        step,
    input  logic                       pop,
    output hdkp_pkg::result_t          head,
    output logic                       not_empty,
    output logic [$clog2(DEPTH):0]     count
);
    import hdkp_pkg::*;

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = PW + 1;

    result_t       mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [PW-1:0] wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + PW'(1);

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(step.count);
        rd_ptr_next = pop ? (rd_ptr_reg + PW'(1)) : rd_ptr_reg;
        count_next  = count_reg + CW'(step.count) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // result storage, up to two writes per cycle
    always_ff @(posedge clk)
    begin
        if (step.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= step.first;
        end
        if (step.count == 2'd2)
        begin
            mem[wr_ptr_plus1] <= step.second;
        end
    end

    assign head      = mem[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

    // fill count never passes the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("result queue count above depth");

    // no write into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (step.count != 2'd0) |-> ((count_reg + CW'(step.count)) <= CW'(DEPTH)))
        else $error("result queue overflow");

    // empty queue has matching pointers
    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (rd_ptr_reg == wr_ptr_reg))
        else $error("pointer mismatch on empty queue");

endmodule

FILE: rtl/core/hd_key_path_parser_core.sv
// channel  | handshake                  | payload
// ---------+----------------------------+----------------------------------------------
// input    | in_valid / in_stall        | char_code
// output   | out_valid / out_stall      | result_kind, child_index, hardened,
//          |                            | error_cause, last_of_path
//
// one character is taken per cycle unless stalled; it is registered, then its results are queued
// a character that closes a component with a stray byte or the end gives two results,
// which leave one after the other through the result queue
// in_stall rises only when the result queue (QUEUE_DEPTH entries) could not hold the
// results of the character in flight and of a new one
// rst_n clears the parser phase, the component and the queue at once
module hd_key_path_parser_core #(
    parameter int unsigned QUEUE_DEPTH = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_code,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  result_kind,
    output logic [31:0] child_index,
    output logic        hardened,
    output logic [2:0]  error_cause,
    output logic        last_of_path
);
    import hdkp_pkg::*;

    localparam int unsigned CW = $clog2(QUEUE_DEPTH) + 1;

    step_out_t     step;
    result_t       head;
    logic          q_not_empty;
    logic [CW-1:0] q_count;
    logic          in_accept;
    logic          out_accept;
    logic          pending;
    logic [CW:0]   reserve;

    // parser with its input register
    hdkp_parse u_parse
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_accept),
        .char_code (char_code),
        .step      (step)
    );

    // result queue
    hdkp_rfifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_rfifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .pop       (out_accept),
        .head      (head),
        .not_empty (q_not_empty),
        .count     (q_count)
    );

    // room for the character in flight plus a new one
    assign pending   = (step.count != 2'd0) || (q_count != '0);
    assign reserve   = {1'b0, q_count} + {{CW{1'b0}}, 1'b0} + (CW + 1)'(step.count);
    assign in_stall  = pending && (reserve > (CW + 1)'(QUEUE_DEPTH - 2));
    assign in_accept = in_valid && !in_stall;

    // output channel
    assign out_valid    = q_not_empty;
    assign out_accept   = q_not_empty && !out_stall;
    assign result_kind  = head.kind;
    assign child_index  = head.index;
    assign hardened     = head.hard;
    assign error_cause  = head.cause;
    assign last_of_path = head.last;

endmodule

FILE: tb/hdkp_result_checker.sv
module hdkp_result_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  char_code,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  result_kind,
    input  logic [31:0] child_index,
    input  logic        hardened,
    input  logic [2:0]  error_cause,
    input  logic        last_of_path,
    output int          fail_count,
    output int          exp_left
);
    timeunit 1ns;
    timeprecision 1ps;
    import hdkp_pkg::*;

    // mirror of the parser state
    phase_t      phase = PH_PREFIX;
    logic [30:0] index_acc = '0;
    logic        digits_seen = 1'b0;
    logic        mark_seen = 1'b0;

    result_t expected_results[$];

    task automatic add_result(input kind_t k, input logic [31:0] idx, input logic h,
                              input cause_t cs, input logic last);
        result_t r;
        r.kind  = k;
        r.index = idx;
        r.hard  = h;
        r.cause = cs;
        r.last  = last;
        expected_results.push_back(r);
    endtask

    task automatic clear_component();
        index_acc   = '0;
        digits_seen = 1'b0;
        mark_seen   = 1'b0;
    endtask

    // a reject on a nonzero byte drains to the terminator
    task automatic reject_path(input logic [7:0] c, input cause_t cs);
        add_result(KIND_REJECT, 32'd0, 1'b0, cs, 1'b1);
        clear_component();
        phase = (c == CH_END) ? PH_PREFIX : PH_DRAIN;
    endtask

    task automatic accept_path();
        add_result(KIND_ACCEPT, 32'd0, 1'b0, CAUSE_NONE, 1'b1);
        clear_component();
        phase = PH_PREFIX;
    endtask

    // byte after a finished component: separator, end or stray
    task automatic close_component(input logic [7:0] c);
        if (c == CH_SLASH)
        begin
            clear_component();
            phase = PH_COMPONENT;
        end
        else if (c == CH_END)
            accept_path();
        else
            reject_path(c, CAUSE_STRAY);
    endtask

    // results caused by one accepted character
    task automatic parse_char(input logic [7:0] c);
        logic        is_digit;
        logic        is_mark;
        logic [35:0] next_val;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        is_mark  = (c == CH_APOS) || (c == CH_LO_H) || (c == CH_UP_H);
        case (phase)
            PH_DRAIN:
            begin
                if (c == CH_END)
                begin
                    phase = PH_PREFIX;
                    clear_component();
                end
            end
            PH_AFTER_M:
            begin
                if (c == CH_SLASH)
                begin
                    clear_component();
                    phase = PH_COMPONENT;
                end
                else if (c == CH_END)
                    accept_path();
                else
                    reject_path(c, CAUSE_PREFIX);
            end
            PH_COMPONENT:
            begin
                if (is_digit)
                begin
                    next_val = {5'd0, index_acc} * 36'd10 + {28'd0, c - CH_ZERO};
                    if (next_val >= 36'h0_8000_0000)
                        reject_path(c, CAUSE_TOO_LARGE);
                    else
                    begin
                        index_acc   = next_val[30:0];
                        digits_seen = 1'b1;
                    end
                end
                else if (!digits_seen)
                begin
                    if (c == CH_END)
                        accept_path();
                    else
                        reject_path(c, CAUSE_NO_DIGITS);
                end
                else if (is_mark)
                begin
                    add_result(KIND_CHILD, {1'b1, index_acc}, 1'b1, CAUSE_NONE, 1'b0);
                    mark_seen = 1'b1;
                    phase     = PH_AFTER_MARK;
                end
                else
                begin
                    add_result(KIND_CHILD, {1'b0, index_acc}, 1'b0, CAUSE_NONE, 1'b0);
                    close_component(c);
                end
            end
            PH_AFTER_MARK:
                close_component(c);
            default:
            begin
                if ((c == CH_LO_M) || (c == CH_UP_M))
                begin
                    clear_component();
                    phase = PH_AFTER_M;
                end
                else if (c == CH_SLASH)
                begin
                    clear_component();
                    phase = PH_COMPONENT;
                end
                else if (c == CH_END)
                    accept_path();
                else
                    reject_path(c, CAUSE_PREFIX);
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] expected,
                               input logic [31:0] actual);
        if (actual !== expected)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, name, expected, actual);
            fail_count++;
        end
    endtask

    // compare one accepted result with the oldest expectation
    task automatic check_result();
        result_t want;
        if (expected_results.size() == 0)
        begin
            $display("%0t: result kind %0d index %0h with nothing expected",
                     $time, result_kind, child_index);
            fail_count++;
        end
        else
        begin
            want = expected_results.pop_front();
            check_field("result_kind", 32'(want.kind), 32'(result_kind));
            check_field("child_index", want.index, child_index);
            check_field("hardened", 32'(want.hard), 32'(hardened));
            check_field("error_cause", 32'(want.cause), 32'(error_cause));
            check_field("last_of_path", 32'(want.last), 32'(last_of_path));
        end
    endtask

    // watch both channels; results are checked before a new request is parsed
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            phase = PH_PREFIX;
            clear_component();
            expected_results.delete();
            fail_count = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_result();
            if (in_valid && !in_stall)
                parse_char(char_code);
        end
        exp_left = expected_results.size();
    end

endmodule

FILE: tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import hdkp_pkg::*;

    localparam int CHAR_TARGET  = 1450;
    localparam int IDLE_LIMIT   = 2000;
    localparam int TAIL_CYCLES  = 16;
    localparam int HOLD_CYCLES  = 200;
    localparam int HOLD_AT_CHAR = 400;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [7:0]  char_code = CH_END;
    logic        out_stall = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [1:0]  result_kind;
    logic [31:0] child_index;
    logic        hardened;
    logic [2:0]  error_cause;
    logic        last_of_path;
    int          fail_count;
    int          exp_left;

    int         chars_sent = 0;
    int         idle_cycles = 0;
    bit         tx_quiet = 1'b0;
    bit         rx_quiet = 1'b0;
    bit         hold_requested = 1'b0;
    bit         hold_done = 1'b0;
    logic [7:0] path_chars[$];

    hd_key_path_parser_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .char_code    (char_code),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_kind  (result_kind),
        .child_index  (child_index),
        .hardened     (hardened),
        .error_cause  (error_cause),
        .last_of_path (last_of_path)
    );

    hdkp_result_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .char_code    (char_code),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_kind  (result_kind),
        .child_index  (child_index),
        .hardened     (hardened),
        .error_cause  (error_cause),
        .last_of_path (last_of_path),
        .fail_count   (fail_count),
        .exp_left     (exp_left)
    );

    always #4 clk = ~clk;

    // offer one character and wait until the request is taken
    task automatic send_char(input logic [7:0] c);
        int gap;
        if ($urandom_range(0, 39) == 0)
            tx_quiet = !tx_quiet;
        gap = (tx_quiet || (hold_requested && !hold_done)) ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= c;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        chars_sent++;
        if (chars_sent == HOLD_AT_CHAR)
            hold_requested = 1'b1;
    endtask

    task automatic send_path();
        foreach (path_chars[i])
            send_char(path_chars[i]);
        path_chars.delete();
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            path_chars.push_back(s[i]);
        path_chars.push_back(CH_END);
    endtask

    // decimal component with optional leading zeros and hardened mark
    task automatic push_component();
        longint unsigned value;
        longint unsigned rem;
        logic [7:0]      digits[$];
        int              pick;
        pick = $urandom_range(0, 15);
        if (pick < 7)
            value = $urandom_range(0, 99);
        else if (pick < 10)
            value = $urandom_range(100, 999999);
        else if (pick < 12)
            value = $urandom_range(0, 32'h7fff_ffff);
        else if (pick == 12)
            value = 0;
        else if (pick == 13)
            value = 64'h7fff_ffff;
        else if (pick == 14)
            value = 64'h7fff_fff8 + $urandom_range(0, 15);
        else
            value = 64'h8000_0000 + $urandom_range(0, 32'hffff_ffff);
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 3)) path_chars.push_back(CH_ZERO);
        do
        begin
            rem = value % 10;
            digits.push_front(CH_ZERO + rem[7:0]);
            value = value / 10;
        end while (value != 0);
        foreach (digits[i])
            path_chars.push_back(digits[i]);
        case ($urandom_range(0, 5))
            0: path_chars.push_back(CH_APOS);
            1: path_chars.push_back(CH_LO_H);
            2: path_chars.push_back(CH_UP_H);
            default: ;
        endcase
    endtask

    // well-formed path: optional m, slash-led components, optional trailing slash
    task automatic build_clean_path();
        int n_comp;
        case ($urandom_range(0, 2))
            1: path_chars.push_back(CH_LO_M);
            2: path_chars.push_back(CH_UP_M);
            default: ;
        endcase
        n_comp = $urandom_range(0, 4);
        for (int i = 0; i < n_comp; i++)
        begin
            path_chars.push_back(CH_SLASH);
            push_component();
        end
        if ($urandom_range(0, 3) == 0)
            path_chars.push_back(CH_SLASH);
        path_chars.push_back(CH_END);
    endtask

    // well-formed path with one byte replaced or inserted
    task automatic build_broken_path();
        int         pos;
        logic [7:0] odd;
        build_clean_path();
        case ($urandom_range(0, 7))
            0: odd = CH_SLASH;
            1: odd = CH_APOS;
            2: odd = CH_LO_H;
            3: odd = CH_UP_M;
            4: odd = CH_NINE;
            5: odd = CH_END;
            default: odd = 8'($urandom_range(1, 255));
        endcase
        pos = $urandom_range(0, path_chars.size() - 1);
        if ($urandom_range(0, 1) == 0)
            path_chars.insert(pos, odd);
        else
            path_chars[pos] = odd;
        if (path_chars[path_chars.size() - 1] != CH_END)
            path_chars.push_back(CH_END);
    endtask

    task automatic build_noise_path();
        int len;
        len = $urandom_range(1, 8);
        repeat (len) path_chars.push_back(8'($urandom_range(0, 255)));
        path_chars.push_back(CH_END);
    endtask

    // receiver: random stall before each result, one long hold-off
    initial
    begin
        int stall_cycles;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_requested && !hold_done)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            if ($urandom_range(0, 39) == 0)
                rx_quiet = !rx_quiet;
            stall_cycles = rx_quiet ? 0 : $urandom_range(0, 3);
            if (stall_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // watchdog on cycles with no request taken on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // stimulus and verdict
    initial
    begin
        int pick;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty path, empty component, bad prefix, digit after mark,
        // top byte value, index overflow with drain
        push_text("");
        push_text("//");
        push_text("Mx");
        push_text("/0'9");
        path_chars.push_back(8'hff);
        path_chars.push_back(CH_END);
        push_text("m/4294967295");
        send_path();

        // random paths, mostly well-formed
        while (chars_sent < CHAR_TARGET)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
                build_clean_path();
            else if (pick < 9)
                build_broken_path();
            else
                build_noise_path();
            send_path();
        end
        in_valid <= 1'b0;

        @(negedge clk);
        while (exp_left != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0 && exp_left == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
